/* hw/rtl/cksa_pkg.sv */
package cksa_pkg;

  // Frame geometry and accumulator format
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int CHANNEL_BITS = 20;

  localparam int NPIX   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(NPIX);
  localparam int WORD_W = 3 * CHANNEL_BITS;

  // Input word fields
  localparam int POS_W   = 16;
  localparam int COLOR_W = 13;
  localparam int CRD_W   = 12;   // rounded pixel coordinate, signed
  localparam int CMP_W   = 14;   // coordinate compare width, signed

  // Shared multiplier operands
  localparam int MUL_A_W = (CHANNEL_BITS > 2 * COLOR_W) ? CHANNEL_BITS : 2 * COLOR_W;
  localparam int MUL_B_W = 13;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Rounded kernel contribution, Q.12
  localparam int ADD_W = 15;
  localparam int RND_SHIFT = 20;
  localparam int BYTE_SHIFT = 12;

  localparam logic [MUL_B_W-1:0] K_CENTER   = MUL_B_W'(218);
  localparam logic [MUL_B_W-1:0] K_SIDE     = MUL_B_W'(77);
  localparam logic [MUL_B_W-1:0] BYTE_SCALE = MUL_B_W'(255);

  localparam logic [CHANNEL_BITS-1:0] ACC_MAX = '1;

  // Kernel taps
  localparam int NUM_TAPS = 5;
  localparam int TAP_BITS = 3;
  localparam logic [TAP_BITS-1:0] TAP_CENTER = TAP_BITS'(0);
  localparam logic [TAP_BITS-1:0] TAP_RIGHT  = TAP_BITS'(1);
  localparam logic [TAP_BITS-1:0] TAP_LEFT   = TAP_BITS'(2);
  localparam logic [TAP_BITS-1:0] TAP_DOWN   = TAP_BITS'(3);
  localparam logic [TAP_BITS-1:0] TAP_UP     = TAP_BITS'(4);
  localparam logic [TAP_BITS-1:0] TAP_LAST   = TAP_BITS'(NUM_TAPS - 1);

  typedef enum logic [1:0] {
    CMD_SPLAT = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_WAIT,
    S_CW,
    S_KW,
    S_TAP_RD,
    S_TAP_WR,
    S_WRITE,
    S_RD,
    S_RD_MUL,
    S_DRAIN,
    S_DONE
  } state_t;

  // Destination of the multiplier result in the cycle after issue
  typedef enum logic [2:0] {
    WB_NONE,
    WB_BASE,
    WB_CW,
    WB_ADD,
    WB_BYTE
  } wb_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  // floor(pos / 64 + 1/2) on a Q9.6 value
  function automatic logic signed [CRD_W-1:0] round_pos(input logic [POS_W-1:0] raw);
    logic [POS_W:0] biased;
    biased = {1'b0, ~raw[POS_W-1], raw[POS_W-2:0]} + (POS_W+1)'(32);
    return $signed({1'b0, biased[POS_W:6]}) - CRD_W'(512);
  endfunction

  function automatic logic signed [CRD_W-1:0] tap_dx(input logic [TAP_BITS-1:0] t);
    logic signed [CRD_W-1:0] d;
    case (t)
      TAP_RIGHT: d = CRD_W'(1);
      TAP_LEFT:  d = -CRD_W'(1);
      default:   d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [CRD_W-1:0] tap_dy(input logic [TAP_BITS-1:0] t);
    logic signed [CRD_W-1:0] d;
    case (t)
      TAP_DOWN: d = CRD_W'(1);
      TAP_UP:   d = -CRD_W'(1);
      default:  d = '0;
    endcase
    return d;
  endfunction

  // Address step of a tap, modulo the address width
  function automatic logic [ADDR_W-1:0] tap_ofs(input logic [TAP_BITS-1:0] t);
    logic [ADDR_W-1:0] d;
    case (t)
      TAP_RIGHT: d = ADDR_W'(1);
      TAP_LEFT:  d = '1;
      TAP_DOWN:  d = ADDR_W'(FRAME_WIDTH);
      TAP_UP:    d = ADDR_W'(0) - ADDR_W'(FRAME_WIDTH);
      default:   d = '0;
    endcase
    return d;
  endfunction

  function automatic logic in_frame(input logic signed [CRD_W-1:0] x,
                                    input logic signed [CRD_W-1:0] y);
    logic signed [CMP_W-1:0] xe;
    logic signed [CMP_W-1:0] ye;
    xe = CMP_W'(x);
    ye = CMP_W'(y);
    return (xe >= 0) && (ye >= 0) &&
           (xe < CMP_W'(FRAME_WIDTH)) && (ye < CMP_W'(FRAME_HEIGHT));
  endfunction

endpackage

/* hw/rtl/cksa_mul.sv */
module cksa_mul
  import cksa_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  // Register the product; the sequencer picks it up in the following cycle
  always_ff @(posedge clk) begin
    p <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

endmodule

/* hw/rtl/cksa_mem.sv */
module cksa_mem
  import cksa_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [NPIX];

  // Single port: one write, one registered read, or both per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* hw/rtl/cross_kernel_splat_accumulator_core.sv */
// Cross-kernel splat accumulator: a frame of RGB accumulators in one single-port
// memory, driven by one shared registered multiplier under a small sequencer.
// A command word is taken when start is high and busy is low; busy then stays
// high until the result, which is shown for one cycle with done high and cannot
// be held off. A new word may be started in the cycle after done. Steps from
// acceptance to done: splat does one address multiply, three color times
// weight multiplies, six kernel multiplies, then a read and a write of the
// memory port for each of the five taps; write does one memory write; read
// does one memory read and three scaling multiplies; an unused command goes
// straight to done. The accumulators are not cleared by reset; every pixel
// must be written before it is read.
module cross_kernel_splat_accumulator_core
  import cksa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic [COLOR_W-1:0]       red_in,
  input  logic [COLOR_W-1:0]       green_in,
  input  logic [COLOR_W-1:0]       blue_in,
  input  logic [COLOR_W-1:0]       weight,
  output logic                     done,
  output logic [7:0]               red_out,
  output logic [7:0]               green_out,
  output logic [7:0]               blue_out,
  output logic [TAP_BITS-1:0]      taps_in_range
);

  state_t state, state_next;
  wb_t    wb, wb_next;
  logic [2:0] wb_idx, wb_idx_next;
  logic [2:0] cnt;
  logic [TAP_BITS-1:0] tap;

  cmd_t cmd_q;
  logic signed [CRD_W-1:0] px, py;
  logic [COLOR_W-1:0]   col [3];
  logic [COLOR_W-1:0]   w;
  logic [2*COLOR_W-1:0] cw [3];
  logic [ADD_W-1:0]     add_v [6];
  logic [ADDR_W-1:0]    base;
  logic [7:0]           byte_q [3];
  logic [TAP_BITS-1:0]  taps;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata;
  logic [CHANNEL_BITS-1:0] acc_rd [3];
  logic [WORD_W-1:0]       sum_word;
  logic [ADDR_W-1:0]       tap_addr;
  logic                    tap_ok;
  logic                    accept;

  cksa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  cksa_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign accept = start && (state == S_IDLE);

  // Current tap position and its frame check
  always_comb begin
    tap_ok   = in_frame(px + tap_dx(tap), py + tap_dy(tap));
    tap_addr = base + tap_ofs(tap);
  end

  // Split the read word and form the saturated sums
  always_comb begin
    logic [CHANNEL_BITS:0] s;
    logic [ADD_W-1:0]      a;
    sum_word = '0;
    for (int c = 0; c < 3; c++) begin
      acc_rd[c] = rdata[c*CHANNEL_BITS +: CHANNEL_BITS];
      a = add_v[2*c + ((tap == TAP_CENTER) ? 0 : 1)];
      s = {1'b0, acc_rd[c]} + (CHANNEL_BITS+1)'(a);
      sum_word[c*CHANNEL_BITS +: CHANNEL_BITS] =
        s[CHANNEL_BITS] ? ACC_MAX : s[CHANNEL_BITS-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) begin
                  state_next = (cmd_t'(cmd) == CMD_NOP) ? S_DONE : S_ADDR;
                end
      S_ADDR:   state_next = (cmd_q == CMD_SPLAT) ? S_CW : S_WAIT;
      S_WAIT:   state_next = (cmd_q == CMD_WRITE) ? S_WRITE : S_RD;
      S_CW:     if (cnt == 3'd2) state_next = S_KW;
      S_KW:     if (cnt == 3'd5) state_next = S_TAP_RD;
      S_TAP_RD: state_next = S_TAP_WR;
      S_TAP_WR: state_next = (tap == TAP_LAST) ? S_DONE : S_TAP_RD;
      S_WRITE:  state_next = S_DONE;
      S_RD:     state_next = S_RD_MUL;
      S_RD_MUL: if (cnt == 3'd2) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier issue, memory port, handshake
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    wb_next       = WB_NONE;
    wb_idx_next   = cnt;
    mem_req       = '0;
    mem_req.addr  = tap_addr;
    mem_req.wdata = sum_word;
    busy          = (state != S_IDLE);
    done          = (state == S_DONE);
    case (state)
      S_ADDR: begin
        mul_a   = MUL_A_W'(py);
        mul_b   = MUL_B_W'(FRAME_WIDTH);
        wb_next = WB_BASE;
      end
      S_CW: begin
        mul_a   = MUL_A_W'(col[cnt[1:0]]);
        mul_b   = w;
        wb_next = WB_CW;
      end
      S_KW: begin
        mul_a   = MUL_A_W'(cw[cnt[2:1]]);
        mul_b   = cnt[0] ? K_SIDE : K_CENTER;
        wb_next = WB_ADD;
      end
      S_TAP_RD: mem_req.re = 1'b1;
      S_TAP_WR: mem_req.we = tap_ok;
      S_WRITE: begin
        mem_req.we    = tap_ok;
        mem_req.wdata = {CHANNEL_BITS'(col[2]), CHANNEL_BITS'(col[1]),
                         CHANNEL_BITS'(col[0])};
      end
      S_RD: mem_req.re = 1'b1;
      S_RD_MUL: begin
        mul_a   = MUL_A_W'(acc_rd[cnt[1:0]]);
        mul_b   = BYTE_SCALE;
        wb_next = WB_BYTE;
      end
      default: ;
    endcase
  end

  // State, counters and writeback destination
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wb     <= WB_NONE;
      wb_idx <= '0;
      cnt    <= '0;
      tap    <= TAP_CENTER;
    end else begin
      state  <= state_next;
      wb     <= wb_next;
      wb_idx <= wb_idx_next;
      cnt    <= (state_next != state) ? 3'd0 : cnt + 3'd1;
      if (accept) begin
        tap <= TAP_CENTER;
      end else if (state == S_TAP_WR) begin
        tap <= tap + TAP_BITS'(1);
      end
    end
  end

  // Capture the command word, then fold in multiplier results
  always_ff @(posedge clk) begin
    logic [MUL_P_W-1:0] rnd;
    logic [MUL_P_W-1:0] scl;
    rnd = (mul_p + (MUL_P_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
    scl = mul_p >> BYTE_SHIFT;
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      px     <= round_pos(pos_x);
      py     <= round_pos(pos_y);
      col[0] <= red_in;
      col[1] <= green_in;
      col[2] <= blue_in;
      w      <= weight;
      taps   <= '0;
      for (int c = 0; c < 3; c++) begin
        byte_q[c] <= '0;
      end
    end else begin
      case (wb)
        WB_BASE: base <= mul_p[ADDR_W-1:0] + ADDR_W'(px);
        WB_CW:   cw[wb_idx[1:0]] <= mul_p[2*COLOR_W-1:0];
        WB_ADD:  add_v[wb_idx] <= rnd[ADD_W-1:0];
        WB_BYTE: begin
          if (!tap_ok) begin
            byte_q[wb_idx[1:0]] <= '0;
          end else if (scl > MUL_P_W'(255)) begin
            byte_q[wb_idx[1:0]] <= 8'd255;
          end else begin
            byte_q[wb_idx[1:0]] <= scl[7:0];
          end
        end
        default: ;
      endcase
      // Count taps inside the frame; a write or read counts its one pixel
      if (state == S_TAP_WR && tap_ok) begin
        taps <= taps + TAP_BITS'(1);
      end else if ((state == S_WRITE || state == S_RD) && tap_ok) begin
        taps <= TAP_BITS'(1);
      end
    end
  end

  assign red_out       = byte_q[0];
  assign green_out     = byte_q[1];
  assign blue_out      = byte_q[2];
  assign taps_in_range = taps;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_TAP_WR || state == S_WRITE))
    else $error("memory write outside a write step");

  a_taps_max: assert property (@(posedge clk) disable iff (rst)
    done |-> taps_in_range <= TAP_BITS'(NUM_TAPS))
    else $error("tap count above kernel size");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    done && cmd_q != CMD_READ |-> red_out == 8'd0 && green_out == 8'd0 &&
      blue_out == 8'd0)
    else $error("color returned for a command other than read");
`endif

endmodule
